// File: hw/rtl/bcv_pkg.sv
// shared types, constants and signature table for the boot catalog validator
package bcv_pkg;

  localparam int POS_W = 7;

  // section lengths, as the position of the final byte
  localparam logic [POS_W-1:0] REC_LAST       = 7'd74;
  localparam logic [POS_W-1:0] CAT_LAST       = 7'd43;
  localparam logic [POS_W-1:0] REC_SECTOR_POS = 7'd71;
  localparam logic [POS_W-1:0] CAT_SECTOR_POS = 7'd40;
  localparam logic [POS_W-1:0] CAT_SUM_END    = 7'd32;
  localparam logic [POS_W-1:0] CAT_PLAT_POS   = 7'd1;
  localparam logic [POS_W-1:0] CAT_KEY0_POS   = 7'd30;
  localparam logic [POS_W-1:0] CAT_KEY1_POS   = 7'd31;
  localparam logic [POS_W-1:0] CAT_BOOT_POS   = 7'd32;
  localparam logic [POS_W-1:0] CAT_MEDIA_POS  = 7'd33;

  localparam logic [7:0] VALIDATION_ID = 8'h01;
  localparam logic [7:0] KEY_BYTE0     = 8'h55;
  localparam logic [7:0] KEY_BYTE1     = 8'hAA;
  localparam logic [7:0] BOOTABLE      = 8'h88;

  localparam logic [3:0] MEDIA_NONE  = 4'd0;
  localparam logic [3:0] MEDIA_F1200 = 4'd1;
  localparam logic [3:0] MEDIA_F1440 = 4'd2;
  localparam logic [3:0] MEDIA_F2880 = 4'd3;
  localparam logic [3:0] MEDIA_HDISK = 4'd4;

  localparam logic [12:0] LEN_F1200 = 13'(1200 * 1024 / 512);
  localparam logic [12:0] LEN_F1440 = 13'(1440 * 1024 / 512);
  localparam logic [12:0] LEN_F2880 = 13'(2880 * 1024 / 512);

  // result status codes
  localparam logic [2:0] ST_RECORD_OK   = 3'd0;
  localparam logic [2:0] ST_IMAGE_OK    = 3'd1;
  localparam logic [2:0] ST_NO_SIG      = 3'd2;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
  localparam logic [2:0] ST_BAD_HEADER  = 3'd4;
  localparam logic [2:0] ST_BAD_SUM     = 3'd5;
  localparam logic [2:0] ST_NO_EMUL     = 3'd6;
  localparam logic [2:0] ST_HD_EMUL     = 3'd7;

  // configuration register indexes
  localparam logic [7:0] REG_ENTRY_INDEX   = 8'd0;
  localparam logic [7:0] REG_HOST_PLATFORM = 8'd1;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] catalog_sector;
    logic [33:0] image_offset;
    logic [12:0] image_length;
    logic        platform_mismatch;
    logic        not_bootable;
  } bcv_result_t;

  // expected record byte: "CD001" at 1..5, spec identifier at 7..29
  function automatic logic [7:0] sig_byte(input logic [POS_W-1:0] pos);
    logic [7:0] b;
    case (pos)
      7'd1:  b = "C";
      7'd2:  b = "D";
      7'd3:  b = "0";
      7'd4:  b = "0";
      7'd5:  b = "1";
      7'd7:  b = "E";
      7'd8:  b = "L";
      7'd9:  b = " ";
      7'd10: b = "T";
      7'd11: b = "O";
      7'd12: b = "R";
      7'd13: b = "I";
      7'd14: b = "T";
      7'd15: b = "O";
      7'd16: b = " ";
      7'd17: b = "S";
      7'd18: b = "P";
      7'd19: b = "E";
      7'd20: b = "C";
      7'd21: b = "I";
      7'd22: b = "F";
      7'd23: b = "I";
      7'd24: b = "C";
      7'd25: b = "A";
      7'd26: b = "T";
      7'd27: b = "I";
      7'd28: b = "O";
      7'd29: b = "N";
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/bcv_parse.sv
// per-byte parse state and result decode for boot record and catalog
module bcv_parse (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_go,
  input  logic [7:0]                data_byte,
  input  logic                      section,
  input  logic                      first_byte,
  input  logic [7:0]                entry_index,
  input  logic [7:0]                host_platform,
  output logic                      closes,
  output bcv_pkg::bcv_result_t      result
);

  logic [bcv_pkg::POS_W-1:0] byte_position_r, byte_position_nxt;
  logic                      current_section_r;
  logic                      signature_failed_r, signature_failed_nxt;
  logic                      header_failed_r, header_failed_nxt;
  logic [15:0]               word_sum_r, word_sum_nxt;
  logic [7:0]                low_byte_hold_r, low_byte_hold_nxt;
  logic [31:0]               sector_gather_r, sector_gather_nxt;
  logic [7:0]                platform_seen_r, platform_seen_nxt;
  logic [7:0]                boot_indicator_r, boot_indicator_nxt;
  logic [3:0]                media_code_r, media_code_nxt;

  logic                      open_sec;
  logic                      skip;
  logic                      consume;
  logic [bcv_pkg::POS_W-1:0] pos;
  logic [bcv_pkg::POS_W-1:0] pos_last;
  logic [bcv_pkg::POS_W-1:0] sector_off;
  logic [1:0]                byte_sel;

  always_comb begin
    open_sec = first_byte ? section : current_section_r;
    skip     = !first_byte && (section != current_section_r);
    pos      = first_byte ? '0 : byte_position_r;
    pos_last = open_sec ? bcv_pkg::CAT_LAST : bcv_pkg::REC_LAST;
    consume  = !skip && (pos <= pos_last);
    closes   = consume && (pos == pos_last);

    // a first byte starts from cleared parse state
    byte_position_nxt    = pos + 7'd1;
    signature_failed_nxt = first_byte ? 1'b0 : signature_failed_r;
    header_failed_nxt    = first_byte ? 1'b0 : header_failed_r;
    word_sum_nxt         = first_byte ? '0 : word_sum_r;
    low_byte_hold_nxt    = first_byte ? '0 : low_byte_hold_r;
    sector_gather_nxt    = first_byte ? '0 : sector_gather_r;
    platform_seen_nxt    = first_byte ? '0 : platform_seen_r;
    boot_indicator_nxt   = first_byte ? '0 : boot_indicator_r;
    media_code_nxt       = first_byte ? '0 : media_code_r;

    sector_off = pos - (open_sec ? bcv_pkg::CAT_SECTOR_POS : bcv_pkg::REC_SECTOR_POS);
    byte_sel   = sector_off[1:0];

    if (!open_sec) begin
      if (pos == '0) begin
        if (data_byte != 8'h00) signature_failed_nxt = 1'b1;
      end else if (pos inside {[7'd1:7'd5], [7'd7:7'd29]}) begin
        if (data_byte != bcv_pkg::sig_byte(pos)) signature_failed_nxt = 1'b1;
      end else if (pos >= bcv_pkg::REC_SECTOR_POS) begin
        sector_gather_nxt = sector_gather_nxt | (32'(data_byte) << {byte_sel, 3'b000});
      end
    end else begin
      // validation entry: little-endian words summed modulo 2^16
      if (pos < bcv_pkg::CAT_SUM_END) begin
        if (pos[0]) word_sum_nxt = word_sum_nxt + {data_byte, low_byte_hold_nxt};
        else        low_byte_hold_nxt = data_byte;
      end
      if (pos == '0 && data_byte != bcv_pkg::VALIDATION_ID) header_failed_nxt = 1'b1;
      if (pos == bcv_pkg::CAT_KEY0_POS && data_byte != bcv_pkg::KEY_BYTE0)
        header_failed_nxt = 1'b1;
      if (pos == bcv_pkg::CAT_KEY1_POS && data_byte != bcv_pkg::KEY_BYTE1)
        header_failed_nxt = 1'b1;
      if (pos == bcv_pkg::CAT_PLAT_POS)  platform_seen_nxt  = data_byte;
      if (pos == bcv_pkg::CAT_BOOT_POS)  boot_indicator_nxt = data_byte;
      if (pos == bcv_pkg::CAT_MEDIA_POS) media_code_nxt = data_byte[3:0];
      if (pos >= bcv_pkg::CAT_SECTOR_POS)
        sector_gather_nxt = sector_gather_nxt | (32'(data_byte) << {byte_sel, 3'b000});
    end
  end

  always_comb begin
    result = '0;
    if (!open_sec) begin
      if (signature_failed_nxt) begin
        result.status = bcv_pkg::ST_NO_SIG;
      end else if (entry_index != 8'h00) begin
        result.status = bcv_pkg::ST_UNSUPPORTED;
      end else begin
        result.status         = bcv_pkg::ST_RECORD_OK;
        result.catalog_sector = sector_gather_nxt;
      end
    end else if (entry_index != 8'h00) begin
      result.status = bcv_pkg::ST_UNSUPPORTED;
    end else if (header_failed_nxt) begin
      result.status = bcv_pkg::ST_BAD_HEADER;
    end else if (word_sum_nxt != 16'h0000) begin
      result.status = bcv_pkg::ST_BAD_SUM;
    end else begin
      result.platform_mismatch = (platform_seen_nxt != host_platform);
      result.not_bootable      = (boot_indicator_nxt != bcv_pkg::BOOTABLE);
      case (media_code_nxt)
        bcv_pkg::MEDIA_NONE:  result.status = bcv_pkg::ST_NO_EMUL;
        bcv_pkg::MEDIA_HDISK: result.status = bcv_pkg::ST_HD_EMUL;
        default: begin
          result.status       = bcv_pkg::ST_IMAGE_OK;
          result.image_offset = {sector_gather_nxt, 2'b00};
          case (media_code_nxt)
            bcv_pkg::MEDIA_F1200: result.image_length = bcv_pkg::LEN_F1200;
            bcv_pkg::MEDIA_F1440: result.image_length = bcv_pkg::LEN_F1440;
            bcv_pkg::MEDIA_F2880: result.image_length = bcv_pkg::LEN_F2880;
            default:              result.image_length = '0;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r    <= '0;
      current_section_r  <= 1'b0;
      signature_failed_r <= 1'b0;
      header_failed_r    <= 1'b0;
      word_sum_r         <= '0;
      low_byte_hold_r    <= '0;
      sector_gather_r    <= '0;
      platform_seen_r    <= '0;
      boot_indicator_r   <= '0;
      media_code_r       <= '0;
    end else if (item_go && consume) begin
      byte_position_r    <= byte_position_nxt;
      current_section_r  <= open_sec;
      signature_failed_r <= signature_failed_nxt;
      header_failed_r    <= header_failed_nxt;
      word_sum_r         <= word_sum_nxt;
      low_byte_hold_r    <= low_byte_hold_nxt;
      sector_gather_r    <= sector_gather_nxt;
      platform_seen_r    <= platform_seen_nxt;
      boot_indicator_r   <= boot_indicator_nxt;
      media_code_r       <= media_code_nxt;
    end
  end

  // position never runs past one beyond the end of the record
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_position_r <= bcv_pkg::REC_LAST + 7'd1)
    else $error("byte position out of range");

  // catalog position stays within the catalog length
  a_cat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    current_section_r |-> byte_position_r <= bcv_pkg::CAT_LAST + 7'd1)
    else $error("catalog position out of range");

  // closing a section leaves the position one past the end
  a_close_pos: assert property (@(posedge clk) disable iff (!rst_n)
    item_go && closes |=> byte_position_r == ($past(pos_last) + 7'd1))
    else $error("position not advanced past end on close");

endmodule

// File: hw/rtl/boot_catalog_validator.sv
// boot_catalog_validator: input register, byte parser and result register
// out_tvalid rises when a section's final byte's result moves into the result register
// throughput: one byte per cycle; only a final byte can wait on a held result
// the parse state updates once per byte in a single pass
// reset: rst_n synchronous active low clears parse state, config registers and valid flags
// no memory, so no clearing pass: the block takes bytes in the cycle after reset
module boot_catalog_validator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [0] section, [1] first_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [34:3] catalog_sector, [68:35] image_offset,
  // [81:69] image_length, [82] platform_mismatch, [83] not_bootable, [87:84] zero
  output logic [87:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic                 s1_valid_r, s1_valid_nxt;
  logic [7:0]           s1_data_r;
  logic                 s1_section_r;
  logic                 s1_first_r;
  logic                 s1_go;
  logic                 closes;
  bcv_pkg::bcv_result_t result;

  logic                 out_valid_r, out_valid_nxt;
  bcv_pkg::bcv_result_t out_res_r;

  logic [7:0]           entry_index_r;
  logic [7:0]           host_platform_r;

  // a byte that gives no result moves on even while the output is held
  assign s1_go     = s1_valid_r && (!closes || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) s1_valid_nxt = 1'b1;
    else if (s1_go)             s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (s1_go && closes) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r    <= in_tdata;
      s1_section_r <= in_tuser[0];
      s1_first_r   <= in_tuser[1];
    end
    if (s1_go && closes) out_res_r <= result;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_index_r   <= '0;
      host_platform_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bcv_pkg::REG_ENTRY_INDEX)   entry_index_r   <= cfg_data;
      if (cfg_index == bcv_pkg::REG_HOST_PLATFORM) host_platform_r <= cfg_data;
    end
  end

  bcv_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_go       (s1_go),
    .data_byte     (s1_data_r),
    .section       (s1_section_r),
    .first_byte    (s1_first_r),
    .entry_index   (entry_index_r),
    .host_platform (host_platform_r),
    .closes        (closes),
    .result        (result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000,
                       out_res_r.not_bootable,
                       out_res_r.platform_mismatch,
                       out_res_r.image_length,
                       out_res_r.image_offset,
                       out_res_r.catalog_sector,
                       out_res_r.status};

  // a new result is only loaded when the result register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && closes |-> !out_valid_r || out_tready)
    else $error("result register overwritten");

  // input side only stalls while a byte sits in the input register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r)
    else $error("input stalled with empty input register");

  // catalog sector is reported only with a good record
  a_cat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status != bcv_pkg::ST_RECORD_OK |->
      out_res_r.catalog_sector == 32'h0)
    else $error("catalog sector set without record ok");

  // image geometry is reported only with image ok
  a_img_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status != bcv_pkg::ST_IMAGE_OK |->
      out_res_r.image_offset == 34'h0 && out_res_r.image_length == 13'h0)
    else $error("image fields set without image ok");

endmodule
